// ===== hdl/grr_pkg.sv =====
// Shared types and constants for the greedy replication reliability block.
package grr_pkg;

	localparam int unsigned QW = 17;
	localparam int unsigned CW = 32;
	localparam int unsigned EW = 38;
	localparam int unsigned IW = 6;
	localparam logic [QW-1:0] ONE_Q = 17'd65536;
	localparam logic [QW-1:0] TARGET_RESET = 17'd62259;
	localparam logic [CW-1:0] COST_SAT = 32'hFFFF_FFFF;
	localparam logic ITEM_RECORD = 1'b0;
	localparam logic ITEM_SUMMARY = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic fetch;
		logic newr_start;
		logic div_start;
		logic mul_start;
		logic commit;
		logic emit_rec;
		logic emit_sum;
		logic clear;
	} grr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic need_more;
		logic div_done;
		logic mul_done;
	} grr_sts_t;

endpackage

// ===== hdl/greedy_replication_reliability_top.sv =====
// Top level of the greedy replication reliability block.
//  channel | signals                                   | transfer
//  config  | cfg_we, cfg_data                          | cfg_we high at clk edge
//  node in | start, busy, node_cost .. last_node       | start high, busy low
//  result  | result_valid, item_kind .. last_result    | one cycle, no stall
// Loading takes one node per cycle; a node that is not last never raises busy.
// After the last node busy rises; each replication runs a decide, a scan over
// all MAX_NODES store entries, a fetch, a multiply for the new reliability, a
// divide (no iterations when the old reliability is zero), a multiply for the
// new total and an emit. The final decide is followed by the summary; busy is
// low again in the cycle that carries the summary. Reset clears the run state
// and sets the target to 62259. The receiver cannot stall, so results never wait.
module greedy_replication_reliability_top
	import grr_pkg::*;
#(
	parameter int unsigned MAX_NODES = 32
)(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [QW-1:0] cfg_data,
	input  logic          start,
	output logic          busy,
	input  logic [CW-1:0] node_cost,
	input  logic [QW-1:0] node_reliability,
	input  logic          is_dummy,
	input  logic [3:0]    replica_count,
	input  logic          last_node,
	output logic          result_valid,
	output logic          item_kind,
	output logic [IW-1:0] node_index,
	output logic [QW-1:0] new_reliability,
	output logic [CW-1:0] new_cost,
	output logic [QW-1:0] total_reliability,
	output logic [EW-1:0] energy_added,
	output logic          target_met,
	output logic          last_result
);

	grr_cmd_t cmd;
	grr_sts_t sts;
	logic [QW-1:0] target_q;

	// Target register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			target_q <= TARGET_RESET;
		else if (cfg_we)
			target_q <= cfg_data;
	end

	grr_ctrl u_ctrl (
		.clk, .arst_n, .start, .last_node, .sts, .busy, .cmd
	);

	grr_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk, .arst_n, .cmd, .node_cost, .node_reliability, .is_dummy,
		.replica_count, .target_q, .sts, .result_valid, .item_kind,
		.node_index, .new_reliability, .new_cost, .total_reliability,
		.energy_added, .target_met, .last_result
	);

endmodule

// ===== hdl/grr_ctrl.sv =====
// Controller state machine that sequences loading and the greedy pass.
module grr_ctrl
	import grr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     last_node,
	input  grr_sts_t sts,
	output logic     busy,
	output grr_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_SCAN, S_FETCH, S_NEWR, S_NEWR_W, S_DIV, S_DIV_W,
		S_MUL, S_MUL_W, S_EMIT, S_SUM
	} state_t;

	state_t state_q;

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		cmd.load = start && !busy;
		unique case (state_q)
			S_IDLE: ;
			S_DECIDE: cmd.scan_start = sts.need_more;
			S_SCAN: cmd.scan_step = 1'b1;
			S_FETCH: cmd.fetch = 1'b1;
			S_NEWR: cmd.newr_start = 1'b1;
			S_NEWR_W: ;
			S_DIV: cmd.div_start = 1'b1;
			S_DIV_W: ;
			S_MUL: cmd.mul_start = 1'b1;
			S_MUL_W: ;
			S_EMIT: begin
				cmd.commit = 1'b1;
				cmd.emit_rec = 1'b1;
			end
			S_SUM: begin
				cmd.emit_sum = 1'b1;
				cmd.clear = 1'b1;
			end
			default: ;
		endcase
	end

	// State register and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start && last_node) begin
					state_q <= S_DECIDE;
					busy <= 1'b1;
				end
				S_DECIDE: state_q <= sts.need_more ? S_SCAN : S_SUM;
				S_SCAN: if (sts.scan_done) state_q <= S_FETCH;
				S_FETCH: state_q <= S_NEWR;
				S_NEWR: state_q <= S_NEWR_W;
				S_NEWR_W: if (sts.mul_done) state_q <= S_DIV;
				S_DIV: state_q <= S_DIV_W;
				S_DIV_W: if (sts.div_done) state_q <= S_MUL;
				S_MUL: state_q <= S_MUL_W;
				S_MUL_W: if (sts.mul_done) state_q <= S_EMIT;
				S_EMIT: state_q <= S_DECIDE;
				S_SUM: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/grr_dp.sv =====
// Datapath: node stores, serial minimum scan, Q1.16 multiply and divide.
module grr_dp
	import grr_pkg::*;
#(
	parameter int unsigned MAX_NODES = 32
)(
	input  logic          clk,
	input  logic          arst_n,
	input  grr_cmd_t      cmd,
	input  logic [CW-1:0] node_cost,
	input  logic [QW-1:0] node_reliability,
	input  logic          is_dummy,
	input  logic [3:0]    replica_count,
	input  logic [QW-1:0] target_q,
	output grr_sts_t      sts,
	output logic          result_valid,
	output logic          item_kind,
	output logic [IW-1:0] node_index,
	output logic [QW-1:0] new_reliability,
	output logic [CW-1:0] new_cost,
	output logic [QW-1:0] total_reliability,
	output logic [EW-1:0] energy_added,
	output logic          target_met,
	output logic          last_result
);

	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned NW = $clog2(MAX_NODES + 1);

	logic [CW-1:0] cost_mem [MAX_NODES];
	logic [QW-1:0] rel_mem [MAX_NODES];
	logic [MAX_NODES-1:0] elig_q;
	logic [NW-1:0] count_q;
	logic [QW-1:0] total_q;
	logic [EW-1:0] energy_q;

	// Scan state: serial walk over the stores for the cheapest eligible node.
	logic [NW-1:0] scan_q;
	logic [NW-1:0] scan_prev;
	logic          scan_done;
	logic [AW-1:0] pick_q;
	logic          found_q;
	logic [CW-1:0] best_q;
	logic [CW-1:0] rd_cost_q;
	logic [QW-1:0] rd_rel_q;

	// Fetched operands of the chosen node.
	logic [CW-1:0] oldc_q;
	logic [QW-1:0] oldr_q;
	logic [QW-1:0] newr_q;
	logic [CW-1:0] newc_q;

	// Pass multiplier: operand registers, product register, rounding stage.
	logic [QW-1:0]   ma_q;
	logic [QW:0]     mb_q;
	logic [2*QW-1:0] prod_s1;
	logic            mv1_q, mv2_q, mdone_q;
	logic [QW-1:0]   mres_q;
	logic [2*QW-1:0] prod_rnd;
	logic [2*QW-17:0] prod_sh;

	// Load multiplier: running total times the incoming reliability.
	logic [2*QW-1:0] lprod;
	logic [2*QW-1:0] lrnd;
	logic [2*QW-17:0] lsh;
	logic [QW-1:0]   load_total;

	// Restoring divider, one quotient bit per cycle.
	logic [QW+16-1:0] dnum_q;
	logic [QW:0]      drem_q;
	logic [QW:0]      dtry;
	logic [5:0]       dcnt_q;
	logic             dbusy_q, ddone_q;
	logic [QW+16-1:0] dquo_q;
	logic [QW-1:0]    div_sat;

	logic [QW-1:0] rel_in;
	logic          do_load;

	assign rel_in = (node_reliability > ONE_Q) ? ONE_Q : node_reliability;
	assign do_load = cmd.load && (count_q < NW'(MAX_NODES));
	assign scan_prev = scan_q - NW'(1);
	assign scan_done = (scan_q == NW'(MAX_NODES));

	// Store writes on load and on commit; registered reads for scan and fetch.
	always_ff @(posedge clk) begin
		if (do_load) begin
			cost_mem[count_q[AW-1:0]] <= node_cost;
			rel_mem[count_q[AW-1:0]] <= rel_in;
		end else if (cmd.commit) begin
			cost_mem[pick_q] <= newc_q;
			rel_mem[pick_q] <= newr_q;
		end
		rd_cost_q <= cost_mem[scan_q[AW-1:0]];
		rd_rel_q <= rel_mem[pick_q];
	end

	// Load multiply, finished within the transfer cycle.
	assign lprod = (2*QW)'(total_q) * (2*QW)'(rel_in);
	assign lrnd = lprod + (2*QW)'(32768);
	assign lsh = lrnd[2*QW-1:16];
	assign load_total = (lsh > (2*QW-16)'(ONE_Q)) ? ONE_Q : lsh[QW-1:0];

	// Pass multiplier: b operand may be 131072 - r, kept 18 bits wide.
	assign prod_rnd = prod_s1 + (2*QW)'(32768);
	assign prod_sh = prod_rnd[2*QW-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv1_q <= 1'b0;
			mv2_q <= 1'b0;
			mdone_q <= 1'b0;
		end else begin
			mv1_q <= cmd.newr_start || cmd.mul_start;
			mv2_q <= mv1_q;
			mdone_q <= mv2_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (2*QW)'(ma_q) * (2*QW)'(mb_q);
		if (mv2_q)
			mres_q <= (prod_sh > (2*QW-16)'(ONE_Q)) ? ONE_Q : prod_sh[QW-1:0];
	end

	// Operand capture for the chosen node and both pass multiplies, and the new reliability.
	always_ff @(posedge clk) begin
		if (cmd.newr_start) begin
			oldr_q <= rd_rel_q;
			ma_q <= rd_rel_q;
			mb_q <= 18'h20000 - {1'b0, rd_rel_q};
		end else if (cmd.mul_start) begin
			ma_q <= total_q;
			mb_q <= {1'b0, newr_q};
		end
		if (cmd.fetch) begin
			oldc_q <= best_q;
			newc_q <= best_q[CW-1] ? COST_SAT : {best_q[CW-2:0], 1'b0};
		end
		if (cmd.div_start)
			newr_q <= mres_q;
	end

	// Divider iteration.
	assign dtry = {drem_q[QW-1:0], dnum_q[QW+16-1]};
	assign div_sat = (dquo_q > (QW+16)'(ONE_Q)) ? ONE_Q : QW'(dquo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				if (oldr_q == '0) begin
					ddone_q <= 1'b1;
				end else begin
					dbusy_q <= 1'b1;
					dcnt_q <= 6'(QW + 16);
				end
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dnum_q <= (QW+16)'({total_q, 16'd0}) + (QW+16)'(oldr_q >> 1);
			drem_q <= '0;
			dquo_q <= '0;
		end else if (dbusy_q) begin
			dnum_q <= {dnum_q[QW+16-2:0], 1'b0};
			if (dtry >= {1'b0, oldr_q}) begin
				drem_q <= dtry - {1'b0, oldr_q};
				dquo_q <= {dquo_q[QW+16-2:0], 1'b1};
			end else begin
				drem_q <= dtry;
				dquo_q <= {dquo_q[QW+16-2:0], 1'b0};
			end
		end
	end

	// Run state and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elig_q <= '0;
			count_q <= '0;
			total_q <= ONE_Q;
			energy_q <= '0;
			scan_q <= '0;
			pick_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
		end else begin
			if (cmd.clear) begin
				elig_q <= '0;
				count_q <= '0;
				total_q <= ONE_Q;
				energy_q <= '0;
			end else if (do_load) begin
				if (!is_dummy && replica_count == 4'd1)
					elig_q[count_q[AW-1:0]] <= 1'b1;
				count_q <= count_q + NW'(1);
				total_q <= load_total;
			end else if (cmd.commit) begin
				elig_q[pick_q] <= 1'b0;
				energy_q <= energy_q + EW'(oldc_q);
				total_q <= mres_q;
			end else if (ddone_q) begin
				total_q <= (oldr_q == '0) ? '0 : div_sat;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				// rd_cost_q holds the entry addressed in the previous cycle.
				if (scan_q != '0 && elig_q[scan_prev[AW-1:0]] &&
				    (!found_q || rd_cost_q <= best_q)) begin
					pick_q <= scan_prev[AW-1:0];
					best_q <= rd_cost_q;
					found_q <= 1'b1;
				end
				if (!scan_done)
					scan_q <= scan_q + NW'(1);
			end
		end
	end

	assign sts.scan_done = scan_done;
	assign sts.need_more = (total_q < target_q) && (elig_q != '0);
	assign sts.div_done = ddone_q;
	assign sts.mul_done = mdone_q;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			item_kind <= ITEM_RECORD;
			last_result <= 1'b0;
		end else begin
			result_valid <= cmd.emit_rec || cmd.emit_sum;
			item_kind <= cmd.emit_sum ? ITEM_SUMMARY : ITEM_RECORD;
			last_result <= cmd.emit_sum;
		end
	end

	always_ff @(posedge clk) begin
		node_index <= cmd.emit_sum ? '0 : IW'(pick_q);
		new_reliability <= cmd.emit_sum ? '0 : newr_q;
		new_cost <= cmd.emit_sum ? '0 : newc_q;
		total_reliability <= cmd.emit_sum ? total_q : mres_q;
		energy_added <= cmd.emit_sum ? energy_q : energy_q + EW'(oldc_q);
		target_met <= cmd.emit_sum ? (total_q >= target_q) : (mres_q >= target_q);
	end

endmodule

// ===== hdl/grr_checker.sv =====
// Port-level checker for the greedy replication reliability block, with its bind.
module grr_port_checks (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_node,
	input logic result_valid,
	input logic item_kind,
	input logic last_result
);

	// A last node starts the pass.
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_node |=> busy) else $error("pass not started");

	// The summary ends the pass.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> !busy) else $error("busy after summary");

	// Summary flag matches item kind.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (item_kind == last_result)) else $error("kind mismatch");

	// No result while idle without a pass.
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result out of pass");

endmodule

bind greedy_replication_reliability_top grr_port_checks u_grr_port_checks (
	.clk, .arst_n, .start, .busy, .last_node, .result_valid, .item_kind, .last_result
);
